FILE: hdl/bitmap_first_fit_block_allocator_defines.svh
// Assertion helpers used by the allocator RTL file.
`ifndef BITMAP_FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define BITMAP_FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

`define BFFA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define BFFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/bffa_pkg.sv
`default_nettype none
package bffa_pkg;
    localparam int LEN_W   = 16;
    localparam int IDX_W   = 10;
    localparam int CNT_W   = 11;
    localparam int STAT_W  = 2;
    localparam int CFG_W   = 13;
    localparam int HDR_W   = 7;
    localparam int DVD_W   = 17;
    localparam int NEED_W  = 18;
    localparam int MAX_BLK = 1024;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOMEM   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_INVALID = 2'd2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [1:0] CFG_BLOCK_BYTES = 2'd0;
    localparam logic [1:0] CFG_HEADER      = 2'd1;
    localparam logic [1:0] CFG_CAPACITY    = 2'd2;
    localparam logic [1:0] CFG_RESERVED    = 2'd3;
endpackage
`default_nettype wire

FILE: hdl/bffa_req_if.sv
`default_nettype none
interface bffa_req_if import bffa_pkg::*; ;
    logic             valid;
    logic             ready;
    logic             func;
    logic [LEN_W-1:0] length_bytes;
    logic [IDX_W-1:0] start_block;
    modport source (output valid, func, length_bytes, start_block, input ready);
    modport sink (input valid, func, length_bytes, start_block, output ready);
endinterface
`default_nettype wire

FILE: hdl/bffa_rsp_if.sv
`default_nettype none
interface bffa_rsp_if import bffa_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  run_index;
    logic [CNT_W-1:0]  block_count;
    modport source (output valid, status, run_index, block_count, input ready);
    modport sink (input valid, status, run_index, block_count, output ready);
endinterface
`default_nettype wire

FILE: hdl/bffa_ram.sv
`default_nettype none
module bffa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: hdl/bffa_div.sv
`default_nettype none
module bffa_div import bffa_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire  [DVD_W-1:0]  i_dividend,
    input  wire  [CFG_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [DVD_W-1:0]  o_quot
);
    logic             r_busy;
    logic [4:0]       r_cnt;
    logic [CFG_W-1:0] r_rem;
    logic [DVD_W-1:0] r_q;
    logic [CFG_W-1:0] r_div;
    logic             r_done;
    logic [CFG_W:0]   rem_sh;
    logic             ge;

    assign rem_sh = {r_rem, r_q[DVD_W-1]};
    assign ge     = rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(DVD_W - 1);
                r_rem  <= '0;
                r_q    <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= ge ? CFG_W'(rem_sh - {1'b0, r_div}) : rem_sh[CFG_W-1:0];
                r_q   <= {r_q[DVD_W-2:0], ge};
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

FILE: hdl/bitmap_first_fit_block_allocator.sv
// Channel   Dir   Payload
// i_req     in    func, length_bytes, start_block
// o_rsp     out   status, run_index, block_count
// i_cfg_*   in    write enable, register index, write data
//
// After reset a clearing pass over min(NUM_BLOCKS, 1024) blocks empties the maps; no request
// is taken meanwhile. An allocate runs a serial division, then scans the occupancy memory
// block by block and marks each granted block in turn.
// A free checks the start mark and clears each released block. One request is in work at a time;
// a result waits in the output register while the block takes the next request.
`default_nettype none
`include "bitmap_first_fit_block_allocator_defines.svh"
module bitmap_first_fit_block_allocator import bffa_pkg::*; #(
    parameter int NUM_BLOCKS = 1024
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire  [1:0]       i_cfg_idx,
    input  wire  [CFG_W-1:0] i_cfg_data,
    bffa_req_if.sink         i_req,
    bffa_rsp_if.source       o_rsp
);
    localparam int DEPTH = (NUM_BLOCKS < MAX_BLK) ? NUM_BLOCKS : MAX_BLK;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_L = CNT_W'(DEPTH);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DIV  = 4'd2;
    localparam logic [3:0] S_SCAN = 4'd3;
    localparam logic [3:0] S_MARK = 4'd4;
    localparam logic [3:0] S_FRD  = 4'd5;
    localparam logic [3:0] S_FCHK = 4'd6;
    localparam logic [3:0] S_FCLR = 4'd7;
    localparam logic [3:0] S_RESP = 4'd8;

    logic [CFG_W-1:0]  r_block_bytes;
    logic [HDR_W-1:0]  r_header;
    logic [CNT_W-1:0]  r_capacity;
    logic [CNT_W-1:0]  r_reserved;

    logic [3:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_i, n_i;
    logic [CNT_W-1:0]  r_j, n_j;
    logic              r_pend, n_pend;
    logic [CNT_W-1:0]  r_run, n_run;
    logic [NEED_W-1:0] r_need, n_need;
    logic [CNT_W-1:0]  r_k, n_k;
    logic [CNT_W:0]    r_end, n_end;
    logic [IDX_W-1:0]  r_sb, n_sb;
    logic [STAT_W-1:0] r_st, n_st;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_st;
    logic [IDX_W-1:0]  r_out_idx;
    logic [CNT_W-1:0]  r_out_cnt;

    logic              accept;
    logic              div_start;
    logic              div_done;
    logic [DVD_W-1:0]  div_quot;
    logic [CFG_W-1:0]  divisor;
    logic [DVD_W-1:0]  dividend;
    logic [CNT_W-1:0]  cap;
    logic [NEED_W-1:0] need_c;
    logic [CNT_W-1:0]  found_idx;
    logic [CNT_W:0]    free_end;

    logic              occ_we, occ_wdata, occ_q;
    logic              sm_we, sm_wdata, sm_q;
    logic [AW-1:0]     sm_waddr;
    logic              rl_we;
    logic [CNT_W-1:0]  rl_q;

    assign accept    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign div_start = accept && (i_req.func == FUNC_ALLOC);
    assign divisor   = (r_block_bytes == '0) ? CFG_W'(1) : r_block_bytes;
    assign dividend  = {1'b0, i_req.length_bytes} + DVD_W'(r_header);
    assign cap       = (r_capacity > DEPTH_L) ? DEPTH_L : r_capacity;
    assign need_c    = NEED_W'(div_quot) + NEED_W'(1);
    assign found_idx = r_j - r_run;
    assign free_end  = (({1'b0, r_sb} + (CNT_W+1)'(rl_q)) > {1'b0, DEPTH_L}) ?
                       {1'b0, DEPTH_L} : ({1'b0, r_sb} + (CNT_W+1)'(rl_q));

    bffa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    bffa_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_occ (
        .i_clk   (i_clk),
        .i_we    (occ_we),
        .i_waddr (r_k[AW-1:0]),
        .i_wdata (occ_wdata),
        .i_raddr (r_i[AW-1:0]),
        .o_rdata (occ_q)
    );

    bffa_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_smark (
        .i_clk   (i_clk),
        .i_we    (sm_we),
        .i_waddr (sm_waddr),
        .i_wdata (sm_wdata),
        .i_raddr (r_sb[AW-1:0]),
        .o_rdata (sm_q)
    );

    bffa_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH)) u_rlen (
        .i_clk   (i_clk),
        .i_we    (rl_we),
        .i_waddr (found_idx[AW-1:0]),
        .i_wdata (r_need[CNT_W-1:0]),
        .i_raddr (r_sb[AW-1:0]),
        .o_rdata (rl_q)
    );

    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_j       = r_j;
        n_pend    = r_pend;
        n_run     = r_run;
        n_need    = r_need;
        n_k       = r_k;
        n_end     = r_end;
        n_sb      = r_sb;
        n_st      = r_st;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        occ_we    = 1'b0;
        occ_wdata = 1'b0;
        sm_we     = 1'b0;
        sm_wdata  = 1'b0;
        sm_waddr  = r_k[AW-1:0];
        rl_we     = 1'b0;
        case (r_state)
            S_CLR: begin
                occ_we = 1'b1;
                sm_we  = 1'b1;
                n_k    = r_k + CNT_W'(1);
                if (r_k == DEPTH_L - CNT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_sb = i_req.start_block;
                    n_state = (i_req.func == FUNC_FREE) ? S_FRD : S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_need = need_c;
                    n_i    = '0;
                    n_pend = 1'b0;
                    n_run  = '0;
                    if (need_c > NEED_W'(cap)) begin
                        n_st    = STAT_NOMEM;
                        n_idx   = '0;
                        n_cnt   = '0;
                        n_state = S_RESP;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_i < cap) begin
                    n_i    = r_i + CNT_W'(1);
                    n_j    = r_i;
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if ((r_j >= r_reserved) && !occ_q) begin
                        n_run = r_run + CNT_W'(1);
                        if (NEED_W'(r_run) + NEED_W'(1) == r_need) begin
                            sm_we    = 1'b1;
                            sm_wdata = 1'b1;
                            sm_waddr = found_idx[AW-1:0];
                            rl_we    = 1'b1;
                            n_k      = found_idx;
                            n_end    = {1'b0, found_idx} + (CNT_W+1)'(r_need[CNT_W-1:0]);
                            n_state  = S_MARK;
                        end
                    end else begin
                        n_run = '0;
                    end
                end else if (!(r_i < cap)) begin
                    n_st    = STAT_NOMEM;
                    n_idx   = '0;
                    n_cnt   = '0;
                    n_state = S_RESP;
                end
            end
            S_MARK: begin
                occ_we    = 1'b1;
                occ_wdata = 1'b1;
                n_k       = r_k + CNT_W'(1);
                if ({1'b0, r_k} + (CNT_W+1)'(1) == r_end) begin
                    n_st    = STAT_OK;
                    n_idx   = IDX_W'(r_end - (CNT_W+1)'(r_need[CNT_W-1:0]));
                    n_cnt   = r_need[CNT_W-1:0];
                    n_state = S_RESP;
                end
            end
            S_FRD: begin
                n_state = S_FCHK;
            end
            S_FCHK: begin
                if (({1'b0, r_sb} < DEPTH_L) && sm_q) begin
                    sm_we    = 1'b1;
                    sm_waddr = r_sb[AW-1:0];
                    n_k      = {1'b0, r_sb};
                    n_end    = free_end;
                    n_st     = STAT_OK;
                    n_idx    = r_sb;
                    n_cnt    = rl_q;
                    n_state  = (free_end > {2'b00, r_sb}) ? S_FCLR : S_RESP;
                end else begin
                    n_st    = STAT_INVALID;
                    n_idx   = '0;
                    n_cnt   = '0;
                    n_state = S_RESP;
                end
            end
            S_FCLR: begin
                occ_we = 1'b1;
                n_k    = r_k + CNT_W'(1);
                if ({1'b0, r_k} + (CNT_W+1)'(1) == r_end) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLR;
            r_k           <= '0;
            r_pend        <= 1'b0;
            r_out_valid   <= 1'b0;
            r_block_bytes <= CFG_W'(16);
            r_header      <= HDR_W'(8);
            r_capacity    <= CNT_W'(1024);
            r_reserved    <= CNT_W'(1);
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_pend  <= n_pend;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BLOCK_BYTES: r_block_bytes <= i_cfg_data;
                    CFG_HEADER:      r_header      <= i_cfg_data[HDR_W-1:0];
                    CFG_CAPACITY:    r_capacity    <= i_cfg_data[CNT_W-1:0];
                    CFG_RESERVED:    r_reserved    <= i_cfg_data[CNT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if ((r_state == S_RESP) && (!r_out_valid || o_rsp.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_run  <= n_run;
        r_need <= n_need;
        r_end  <= n_end;
        r_sb   <= n_sb;
        r_st   <= n_st;
        r_idx  <= n_idx;
        r_cnt  <= n_cnt;
        if ((r_state == S_RESP) && (!r_out_valid || o_rsp.ready)) begin
            r_out_st  <= r_st;
            r_out_idx <= r_idx;
            r_out_cnt <= r_cnt;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_st;
    assign o_rsp.run_index   = r_out_idx;
    assign o_rsp.block_count = r_out_cnt;

    `BFFA_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, o_rsp.valid && (o_rsp.status != STAT_OK), (o_rsp.run_index == '0) && (o_rsp.block_count == '0))
    `BFFA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, r_state != S_IDLE)
    `BFFA_ASSERT_IMPL(a_run_below_need, i_clk, i_rst_n, r_state == S_SCAN, NEED_W'(r_run) < r_need)
endmodule
`default_nettype wire
